FILE: sv/lcuce_pkg.sv
package lcuce_pkg;

  localparam logic [7:0]  PktTypeCommand = 8'h01;
  localparam logic [15:0] OpcodeConnUpdate = 16'h2013;
  localparam logic [7:0]  ParamLength = 8'd14;
  localparam logic [15:0] HandleLimit = 16'h0EFF;
  localparam logic [15:0] IntervalLow = 16'd6;
  localparam logic [15:0] IntervalHigh = 16'd3200;
  localparam logic [15:0] LatencyHigh = 16'd499;
  localparam logic [15:0] TimeoutLow = 16'd10;
  localparam logic [15:0] TimeoutHigh = 16'd3200;
  localparam int unsigned PacketLen = 18;
  localparam int unsigned IdxW = $clog2(PacketLen);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(PacketLen - 1);

  typedef struct packed {
    logic [15:0] conn_handle;
    logic [15:0] interval_min;
    logic [15:0] interval_max;
    logic [15:0] periph_latency;
    logic [15:0] sup_timeout;
    logic        rejected;
  } cmd_t;

endpackage

FILE: sv/lcuce_front.sv
module lcuce_front
  import lcuce_pkg::*;
(
  input  logic [15:0] conn_handle,
  input  logic [15:0] interval_min,
  input  logic [15:0] interval_max,
  input  logic [15:0] periph_latency,
  input  logic [15:0] sup_timeout,
  output cmd_t        cmd
);

  logic        range_ok;
  logic [9:0]  lat_p1;
  logic [21:0] prod;
  logic [21:0] tmo_x4;

  // ranges bound latency to 9 bits and interval to 12 bits
  assign lat_p1 = {1'b0, periph_latency[8:0]} + 10'd1;
  assign prod   = 22'(lat_p1 * interval_max[11:0]);
  assign tmo_x4 = {8'd0, sup_timeout[11:0], 2'b00};

  assign range_ok = (conn_handle <= HandleLimit) &&
                    (interval_min >= IntervalLow) &&
                    (interval_max <= IntervalHigh) &&
                    (interval_min <= interval_max) &&
                    (periph_latency <= LatencyHigh) &&
                    (sup_timeout >= TimeoutLow) &&
                    (sup_timeout <= TimeoutHigh);

  always_comb begin
    cmd.conn_handle    = conn_handle;
    cmd.interval_min   = interval_min;
    cmd.interval_max   = interval_max;
    cmd.periph_latency = periph_latency;
    cmd.sup_timeout    = sup_timeout;
    cmd.rejected       = !(range_ok && (tmo_x4 > prod));
  end

endmodule

FILE: sv/lcuce_queue.sv
module lcuce_queue
  import lcuce_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t wr_cmd,
  output logic full,
  input  logic pop,
  output logic empty,
  output cmd_t rd_cmd
);

  cmd_t       mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push, do_pop;

  assign full    = (count_r == 2'd2);
  assign empty   = (count_r == 2'd0);
  assign rd_cmd  = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_cmd;
    end
  end

endmodule

FILE: sv/lcuce_back.sv
module lcuce_back
  import lcuce_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_empty,
  input  cmd_t       q_cmd,
  output logic       q_pop,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [7:0] out_packet_byte,
  output logic       out_final_byte,
  output logic       out_rejected
);

  cmd_t            cur_r;
  logic            busy_r, busy_nxt;
  logic [IdxW-1:0] idx_r, idx_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [7:0]      byte_r;
  logic            final_r;
  logic            rej_r;
  logic            out_free, adv, last, take;
  logic [7:0]      sel_byte;

  assign out_free = !out_valid_r || out_pop;
  assign adv      = busy_r && out_free;
  assign last     = cur_r.rejected || (idx_r == LastIdx);
  assign take     = !q_empty && (!busy_r || (adv && last));
  assign q_pop    = take;

  always_comb begin
    case (idx_r)
      5'd0:    sel_byte = PktTypeCommand;
      5'd1:    sel_byte = OpcodeConnUpdate[7:0];
      5'd2:    sel_byte = OpcodeConnUpdate[15:8];
      5'd3:    sel_byte = ParamLength;
      5'd4:    sel_byte = cur_r.conn_handle[7:0];
      5'd5:    sel_byte = cur_r.conn_handle[15:8];
      5'd6:    sel_byte = cur_r.interval_min[7:0];
      5'd7:    sel_byte = cur_r.interval_min[15:8];
      5'd8:    sel_byte = cur_r.interval_max[7:0];
      5'd9:    sel_byte = cur_r.interval_max[15:8];
      5'd10:   sel_byte = cur_r.periph_latency[7:0];
      5'd11:   sel_byte = cur_r.periph_latency[15:8];
      5'd12:   sel_byte = cur_r.sup_timeout[7:0];
      5'd13:   sel_byte = cur_r.sup_timeout[15:8];
      default: sel_byte = 8'd0;
    endcase
  end

  always_comb begin
    busy_nxt      = busy_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    if (out_pop) begin
      out_valid_nxt = 1'b0;
    end
    if (adv) begin
      out_valid_nxt = 1'b1;
      idx_nxt       = idx_r + 1'b1;
      if (last) begin
        busy_nxt = 1'b0;
      end
    end
    if (take) begin
      busy_nxt = 1'b1;
      idx_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cur_r <= q_cmd;
    end
    if (adv) begin
      byte_r  <= cur_r.rejected ? 8'd0 : sel_byte;
      final_r <= last;
      rej_r   <= cur_r.rejected;
    end
  end

  assign out_empty       = !out_valid_r;
  assign out_packet_byte = byte_r;
  assign out_final_byte  = final_r;
  assign out_rejected    = rej_r;

endmodule

FILE: sv/le_connection_update_command_encoder_unit.sv
// A command passes the queue, the serialiser register and the output register in turn.
// One word per cycle while out_pop is high; a valid command is 18 words, a rejected one 1.
// A two-entry command queue between validation and the byte serialiser sets the input slack.
// Reset: synchronous, active low; clears the queue, the serialiser and the output stage.
module le_connection_update_command_encoder_unit
  import lcuce_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [15:0] in_conn_handle,
  input  logic [15:0] in_interval_min,
  input  logic [15:0] in_interval_max,
  input  logic [15:0] in_periph_latency,
  input  logic [15:0] in_sup_timeout,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [7:0]  out_packet_byte,
  output logic        out_final_byte,
  output logic        out_rejected
);

  cmd_t front_cmd;
  cmd_t q_cmd;
  logic q_empty;
  logic q_pop;

  lcuce_front u_front (
    .conn_handle    (in_conn_handle),
    .interval_min   (in_interval_min),
    .interval_max   (in_interval_max),
    .periph_latency (in_periph_latency),
    .sup_timeout    (in_sup_timeout),
    .cmd            (front_cmd)
  );

  lcuce_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (in_push),
    .wr_cmd (front_cmd),
    .full   (in_full),
    .pop    (q_pop),
    .empty  (q_empty),
    .rd_cmd (q_cmd)
  );

  lcuce_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_cmd           (q_cmd),
    .q_pop           (q_pop),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_packet_byte (out_packet_byte),
    .out_final_byte  (out_final_byte),
    .out_rejected    (out_rejected)
  );

endmodule
